@@ hw/rtl/rpa_pkg.sv @@
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes for the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

  // Width of one share count
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  // Reset value of the first free address register
  localparam logic [31:0] FIRST_FREE_RESET = 32'h8000_0000;

  // Request codes
  localparam logic [1:0] ACT_ALLOC_JUNK = 2'd0;
  localparam logic [1:0] ACT_ALLOC_ZERO = 2'd1;
  localparam logic [1:0] ACT_FREE       = 2'd2;
  localparam logic [1:0] ACT_ADD_REF    = 2'd3;

  // Result status codes
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_EMPTY      = 3'd1;
  localparam logic [2:0] STAT_BAD_ADDR   = 3'd2;
  localparam logic [2:0] STAT_SHARED     = 3'd3;
  localparam logic [2:0] STAT_ZERO_COUNT = 3'd4;

  // Fill request codes
  localparam logic [1:0] FILL_NONE       = 2'd0;
  localparam logic [1:0] FILL_JUNK_ALLOC = 2'd1;
  localparam logic [1:0] FILL_ZERO       = 2'd2;
  localparam logic [1:0] FILL_JUNK_FREE  = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } rpa_state_t;

  // Free stack commands from the sequencer
  typedef struct packed {
    logic pop;
    logic push;
  } stk_cmd_t;

  // Free stack status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

endpackage

@@ hw/rtl/rpa_count_mem.sv @@
// ----------------------------------------------------------------------------
// rpa_count_mem
// Share count memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rpa_count_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                   clk,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [rpa_pkg::CNT_W-1:0] rdata,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [rpa_pkg::CNT_W-1:0] wdata
);
  import rpa_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rpa_free_stack.sv @@
// ----------------------------------------------------------------------------
// rpa_free_stack
// LIFO of free page indices held in a memory, with its depth counter.
// ----------------------------------------------------------------------------
module rpa_free_stack #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rpa_pkg::stk_cmd_t   cmd,
  input  logic [AW-1:0]       wdata,
  output logic [AW-1:0]       rdata,
  output rpa_pkg::stk_stat_t  stat
);
  import rpa_pkg::*;

  logic [AW-1:0] mem [DEPTH];
  logic [DW-1:0] depth_r;
  logic [DW-1:0] depth_nxt;
  logic          do_pop;
  logic          do_push;

  assign stat.empty = (depth_r == '0);
  assign stat.full  = (depth_r == DW'(DEPTH));

  // Drop a pop on empty and a push on full
  assign do_pop  = cmd.pop && !stat.empty;
  assign do_push = cmd.push && !stat.full;

  always_comb begin
    depth_nxt = depth_r;
    if (do_pop) begin
      depth_nxt = depth_r - DW'(1);
    end else if (do_push) begin
      depth_nxt = depth_r + DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // Push writes the slot above the top
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[depth_r[AW-1:0]] <= wdata;
    end
  end

  // Pop reads the top entry, registered
  always_ff @(posedge clk) begin
    if (do_pop) begin
      rdata <= mem[AW'(depth_r - DW'(1))];
    end
  end

endmodule

@@ hw/rtl/rpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer: clears the counts after reset, checks addresses, and runs the
// read-modify-write of one count and the stack access for each request.
// ----------------------------------------------------------------------------
module rpa_ctrl #(
  parameter int          PAGE_COUNT   = 32768,
  parameter int          PAGE_BYTES   = 4096,
  parameter logic [31:0] BASE_ADDRESS = 32'h8000_0000,
  parameter int          AW           = 15
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic [31:0]               in_page_address,
  input  logic                      cfg_wr_en,
  input  logic [31:0]               cfg_wr_data,
  output logic                      cnt_re,
  output logic [AW-1:0]             cnt_raddr,
  input  logic [rpa_pkg::CNT_W-1:0] cnt_rdata,
  output logic                      cnt_we,
  output logic [AW-1:0]             cnt_waddr,
  output logic [rpa_pkg::CNT_W-1:0] cnt_wdata,
  output rpa_pkg::stk_cmd_t         stk_cmd,
  input  rpa_pkg::stk_stat_t        stk_stat,
  input  logic [AW-1:0]             stk_rdata,
  output logic [AW-1:0]             stk_wdata,
  output logic                      out_valid,
  output logic [31:0]               out_result_address,
  output logic [2:0]                out_status,
  output logic [7:0]                out_share_count,
  output logic [1:0]                out_fill_kind
);
  import rpa_pkg::*;

  localparam int          SHIFT     = $clog2(PAGE_BYTES);
  localparam logic [63:0] RANGE_END = 64'(BASE_ADDRESS) + 64'(PAGE_COUNT) * 64'(PAGE_BYTES);

  rpa_state_t       state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [31:0]      first_free_r;
  logic [1:0]       act_r;
  logic [AW-1:0]    page_r;
  logic             bad_r;
  logic             empty_r;

  logic             accept;
  logic             is_alloc;
  logic             in_range;
  logic             aligned;
  logic             bad_in;
  logic [31:0]      addr_off;
  logic [AW-1:0]    page_in;

  // Execute-cycle decode
  logic             ex_we;
  logic [AW-1:0]    ex_waddr;
  logic [CNT_W-1:0] ex_wdata;
  logic             ex_push;
  logic [31:0]      ex_addr;
  logic [2:0]       ex_status;
  logic [CNT_W-1:0] ex_count;
  logic [1:0]       ex_fill;
  logic [CNT_W-1:0] dec_count;

  assign accept   = start && !busy;
  assign is_alloc = (in_action == ACT_ALLOC_JUNK) || (in_action == ACT_ALLOC_ZERO);

  // Address checks on the incoming word
  assign addr_off = in_page_address - BASE_ADDRESS;
  assign page_in  = AW'(64'(addr_off) >> SHIFT);
  assign in_range = (in_page_address >= BASE_ADDRESS) &&
                    (64'(in_page_address) < RANGE_END);
  assign aligned  = (in_page_address[SHIFT-1:0] == '0);

  always_comb begin
    if (in_action == ACT_FREE) begin
      bad_in = !aligned || (in_page_address < first_free_r) || !in_range;
    end else begin
      bad_in = !in_range;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(PAGE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Hold the first free address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_free_r <= FIRST_FREE_RESET;
    end else if (cfg_wr_en) begin
      first_free_r <= cfg_wr_data;
    end
  end

  // Capture the request at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_action;
      page_r  <= page_in;
      bad_r   <= bad_in;
      empty_r <= stk_stat.empty;
    end
  end

  assign dec_count = cnt_rdata - CNT_W'(1);

  // Modify step: count data and stack top are valid now
  always_comb begin
    ex_we     = 1'b0;
    ex_waddr  = page_r;
    ex_wdata  = '0;
    ex_push   = 1'b0;
    ex_addr   = '0;
    ex_status = STAT_OK;
    ex_count  = '0;
    ex_fill   = FILL_NONE;
    case (act_r) inside
      ACT_ALLOC_JUNK, ACT_ALLOC_ZERO: begin
        if (empty_r) begin
          ex_status = STAT_EMPTY;
        end else begin
          ex_we    = 1'b1;
          ex_waddr = stk_rdata;
          ex_wdata = CNT_W'(1);
          ex_addr  = 32'(64'(BASE_ADDRESS) + (64'(stk_rdata) << SHIFT));
          ex_count = CNT_W'(1);
          ex_fill  = (act_r == ACT_ALLOC_JUNK) ? FILL_JUNK_ALLOC : FILL_ZERO;
        end
      end
      ACT_FREE: begin
        if (bad_r) begin
          ex_status = STAT_BAD_ADDR;
        end else if (cnt_rdata == '0) begin
          ex_status = STAT_ZERO_COUNT;
        end else begin
          ex_we    = 1'b1;
          ex_wdata = dec_count;
          if (dec_count != '0) begin
            ex_status = STAT_SHARED;
            ex_count  = dec_count;
          end else begin
            ex_push = 1'b1;
            ex_fill = FILL_JUNK_FREE;
          end
        end
      end
      default: begin
        // add reference, saturating
        if (bad_r) begin
          ex_status = STAT_BAD_ADDR;
        end else begin
          ex_we    = 1'b1;
          ex_wdata = (cnt_rdata == CNT_MAX) ? CNT_MAX : cnt_rdata + CNT_W'(1);
          ex_count = ex_wdata;
        end
      end
    endcase
  end

  // Outputs by state
  always_comb begin
    busy         = 1'b1;
    cnt_re       = 1'b0;
    cnt_raddr    = page_in;
    cnt_we       = 1'b0;
    cnt_waddr    = ex_waddr;
    cnt_wdata    = ex_wdata;
    stk_cmd.pop  = 1'b0;
    stk_cmd.push = 1'b0;
    stk_wdata    = page_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
      end
      ST_IDLE: begin
        busy        = 1'b0;
        cnt_re      = start;
        stk_cmd.pop = start && is_alloc;
      end
      ST_EXEC: begin
        cnt_we       = ex_we;
        stk_cmd.push = ex_push;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Result strobe follows the execute cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      out_result_address <= ex_addr;
      out_status         <= ex_status;
      out_share_count    <= ex_count;
      out_fill_kind      <= ex_fill;
    end
  end

endmodule

@@ hw/rtl/refcounted_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit
// Page allocator with a LIFO free list and an 8-bit share count per page.
//
//   channel  handshake            payload
//   -------  -------------------  ---------------------------------------------
//   input    start && !busy       in_action, in_page_address
//   result   out_valid (1 cycle)  out_result_address, out_status,
//                                 out_share_count, out_fill_kind
//   config   cfg_wr_en            cfg_wr_data (first free address)
//
// For each word, accept reads the count memory and, for an allocate, pops the
// stack; the next cycle writes the count back and pushes a freed page; the result
// shows the cycle after that, while the next word may already be accepted.
// After reset a clearing pass zeroes the count memory with busy high; config
// writes are taken throughout.
// The receiver cannot stall; each result is held for exactly one cycle.
// PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_unit #(
  parameter int          PAGE_COUNT   = 32768,
  parameter int          PAGE_BYTES   = 4096,
  parameter logic [31:0] BASE_ADDRESS = 32'h8000_0000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_page_address,
  output logic        out_valid,
  output logic [31:0] out_result_address,
  output logic [2:0]  out_status,
  output logic [7:0]  out_share_count,
  output logic [1:0]  out_fill_kind,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import rpa_pkg::*;

  localparam int AW = $clog2(PAGE_COUNT);
  localparam int DW = $clog2(PAGE_COUNT + 1);

  logic             cnt_re;
  logic [AW-1:0]    cnt_raddr;
  logic [CNT_W-1:0] cnt_rdata;
  logic             cnt_we;
  logic [AW-1:0]    cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  stk_cmd_t         stk_cmd;
  stk_stat_t        stk_stat;
  logic [AW-1:0]    stk_rdata;
  logic [AW-1:0]    stk_wdata;

  rpa_ctrl #(
    .PAGE_COUNT   (PAGE_COUNT),
    .PAGE_BYTES   (PAGE_BYTES),
    .BASE_ADDRESS (BASE_ADDRESS),
    .AW           (AW)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_page_address    (in_page_address),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .cnt_re             (cnt_re),
    .cnt_raddr          (cnt_raddr),
    .cnt_rdata          (cnt_rdata),
    .cnt_we             (cnt_we),
    .cnt_waddr          (cnt_waddr),
    .cnt_wdata          (cnt_wdata),
    .stk_cmd            (stk_cmd),
    .stk_stat           (stk_stat),
    .stk_rdata          (stk_rdata),
    .stk_wdata          (stk_wdata),
    .out_valid          (out_valid),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .out_share_count    (out_share_count),
    .out_fill_kind      (out_fill_kind)
  );

  rpa_count_mem #(
    .DEPTH (PAGE_COUNT),
    .AW    (AW)
  ) u_count_mem (
    .clk   (clk),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata)
  );

  rpa_free_stack #(
    .DEPTH (PAGE_COUNT),
    .AW    (AW),
    .DW    (DW)
  ) u_free_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .wdata (stk_wdata),
    .rdata (stk_rdata),
    .stat  (stk_stat)
  );

`ifndef SYNTHESIS
  // Every accepted word produces its result strobe, registered after the execute state
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("result strobe missing after accept");

  // A result only follows work with busy high
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without execute cycle");

  // A release never reports a remaining count
  a_release_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_kind == FILL_JUNK_FREE |->
      out_status == STAT_OK && out_share_count == 8'd0)
    else $error("release result inconsistent");

  // Only a successful allocate returns an address
  a_addr_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_result_address == 32'd0)
    else $error("address returned on a failed request");
`endif

endmodule
